// ----- rtl/efc_pkg.sv -----
package efc_pkg;

   localparam int TimeW    = 16;
   localparam int DriveW   = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // register reset values
   localparam logic [TimeW-1:0]         UpTimeRst    = 16'd1500;
   localparam logic [TimeW-1:0]         DownTimeRst  = 16'd1000;
   localparam logic [TimeW-1:0]         HoldTimeRst  = 16'd1000;
   localparam logic [TimeW-1:0]         IdleTimeRst  = 16'd20000;
   localparam logic signed [DriveW-1:0] UpDriveRst   = -8'sd100;
   localparam logic signed [DriveW-1:0] DownDriveRst = 8'sd15;
   localparam logic signed [DriveW-1:0] HoldDriveRst = -8'sd25;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_UP_TIME    = 3'd0,
      CSR_DOWN_TIME  = 3'd1,
      CSR_HOLD_TIME  = 3'd2,
      CSR_IDLE_TIME  = 3'd3,
      CSR_UP_DRIVE   = 3'd4,
      CSR_DOWN_DRIVE = 3'd5,
      CSR_HOLD_DRIVE = 3'd6
   } efc_csr_index_type;

   typedef struct packed {
      logic [TimeW-1:0]         up_time;
      logic [TimeW-1:0]         down_time;
      logic [TimeW-1:0]         hold_time;
      logic [TimeW-1:0]         idle_time;
      logic signed [DriveW-1:0] up_drive;
      logic signed [DriveW-1:0] down_drive;
      logic signed [DriveW-1:0] hold_drive;
   } efc_cfg_type;

endpackage

// ----- rtl/efc_csr.sv -----
module efc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [efc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [efc_pkg::CsrDataW-1:0]   csr_wdata,
   output efc_pkg::efc_cfg_type           cfg
);
   import efc_pkg::*;

   efc_cfg_type cfg_ff;
   efc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_UP_TIME:    cfg_in.up_time    = csr_wdata[TimeW-1:0];
            CSR_DOWN_TIME:  cfg_in.down_time  = csr_wdata[TimeW-1:0];
            CSR_HOLD_TIME:  cfg_in.hold_time  = csr_wdata[TimeW-1:0];
            CSR_IDLE_TIME:  cfg_in.idle_time  = csr_wdata[TimeW-1:0];
            CSR_UP_DRIVE:   cfg_in.up_drive   = csr_wdata[DriveW-1:0];
            CSR_DOWN_DRIVE: cfg_in.down_drive = csr_wdata[DriveW-1:0];
            CSR_HOLD_DRIVE: cfg_in.hold_drive = csr_wdata[DriveW-1:0];
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_time    <= UpTimeRst;
         cfg_ff.down_time  <= DownTimeRst;
         cfg_ff.hold_time  <= HoldTimeRst;
         cfg_ff.idle_time  <= IdleTimeRst;
         cfg_ff.up_drive   <= UpDriveRst;
         cfg_ff.down_drive <= DownDriveRst;
         cfg_ff.hold_drive <= HoldDriveRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/elevator_floor_controller_unit.sv -----
// Elevator floor controller, lowest pending call first.
// Request channel (req_valid / req_stall / req_call_buttons): one transfer per
// millisecond tick carrying the call buttons, one bit per floor.
// Response channel (rsp_valid / rsp_stall / rsp_*): one transfer per request
// with the motor drive, floor lamps, current floor and target floor as they
// stood before that tick was applied.
// The response is registered and valid the cycle after the request transfer.
// Throughput is one tick per cycle unless rsp_stall holds; the single output
// register lets a new request in whenever it is empty or being drained in the
// same cycle, so the whole tick update is one combinational pass.
// When the receiver stalls with a response pending, req_stall rises and the
// controller state holds until the response is taken.
// Reset (synchronous) loads the default timing and drive registers, clears
// calls and timers, parks the car at floor 0 and selects hold drive.
// The csr_ port writes one of the seven timing and drive registers per write;
// write them only while no tick is in flight.
module elevator_floor_controller_unit #(
   parameter int FLOORS = 3
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [efc_pkg::CsrIdxW-1:0]             csr_index,
   input  logic [efc_pkg::CsrDataW-1:0]            csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [FLOORS-1:0]                       req_call_buttons,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [efc_pkg::DriveW-1:0]       rsp_motor_drive,
   output logic [FLOORS-1:0]                       rsp_floor_lamps,
   output logic [((FLOORS > 1) ? $clog2(FLOORS) : 1)-1:0] rsp_at_floor,
   output logic [((FLOORS > 1) ? $clog2(FLOORS) : 1)-1:0] rsp_heading_floor
);
   import efc_pkg::*;

   localparam int FloorW   = (FLOORS > 1) ? $clog2(FLOORS) : 1;
   localparam int LimitW   = TimeW + FloorW;
   localparam int MoveW    = LimitW + 1;

   efc_cfg_type cfg;

   efc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // controller state
   logic [FLOORS-1:0]        call_ff, call_in;
   logic [FloorW-1:0]        cur_ff, cur_in;
   logic [FloorW-1:0]        tgt_ff, tgt_in;
   logic [TimeW-1:0]         idle_ff, idle_in;
   logic [MoveW-1:0]         move_ff, move_in;
   logic [LimitW-1:0]        limit_ff, limit_in;
   logic signed [DriveW-1:0] drive_ff, drive_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DriveW-1:0] rsp_drive_ff;
   logic [FLOORS-1:0]        rsp_lamps_ff;
   logic [FloorW-1:0]        rsp_at_ff;
   logic [FloorW-1:0]        rsp_head_ff;

   logic                     req_accept;

   // tick datapath
   logic [TimeW-1:0]         idle_inc, idle_pressed;
   logic [MoveW-1:0]         move_inc;
   logic [FLOORS-1:0]        calls_pressed, calls_idle;
   logic                     idle_hit;
   logic                     hold_hit;
   logic [MoveW-1:0]         dwell_end;
   logic                     dwell_done;
   logic [FLOORS-1:0]        calls_left;
   logic [FLOORS-1:0]        lowest_bit;
   logic [FloorW-1:0]        lowest_idx;
   logic [FloorW-1:0]        pick_tgt;
   logic                     go_up, go_down;
   logic [FloorW-1:0]        floor_span;
   logic [TimeW-1:0]         time_sel;
   logic [LimitW-1:0]        pick_limit;
   logic signed [DriveW-1:0] pick_drive;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      idle_inc      = (idle_ff == '1) ? idle_ff : idle_ff + TimeW'(1);
      move_inc      = (move_ff == '1) ? move_ff : move_ff + MoveW'(1);

      // latch presses, restart idle count
      calls_pressed = call_ff | req_call_buttons;
      idle_pressed  = (|req_call_buttons) ? '0 : idle_inc;

      // idle too long: drop calls and head for ground floor
      idle_hit      = idle_pressed > cfg.idle_time;
      calls_idle    = idle_hit ? FLOORS'(1) : calls_pressed;

      hold_hit      = move_inc > MoveW'(limit_ff);
      dwell_end     = MoveW'(limit_ff) + MoveW'(cfg.hold_time);
      dwell_done    = move_inc > dwell_end;

      // arrive at target, clear its call, take lowest pending call
      calls_left    = calls_idle & ~(FLOORS'(1) << tgt_ff);
      lowest_bit    = calls_left & (~calls_left + FLOORS'(1));
      lowest_idx    = '0;
      for (int i = 0; i < FLOORS; i++) begin
         if (lowest_bit[i]) begin
            lowest_idx = lowest_idx | FloorW'(i);
         end
      end
      pick_tgt      = (|calls_left) ? lowest_idx : tgt_ff;

      go_up         = pick_tgt > tgt_ff;
      go_down       = pick_tgt < tgt_ff;
      floor_span    = go_up ? (pick_tgt - tgt_ff) : (tgt_ff - pick_tgt);
      time_sel      = go_up ? cfg.up_time : cfg.down_time;
      pick_limit    = (go_up | go_down) ? LimitW'(time_sel) * LimitW'(floor_span) : '0;
      if (go_up) begin
         pick_drive = cfg.up_drive;
      end else if (go_down) begin
         pick_drive = cfg.down_drive;
      end else begin
         pick_drive = cfg.hold_drive;
      end
   end

   always_comb begin
      call_in  = call_ff;
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      idle_in  = idle_ff;
      move_in  = move_ff;
      limit_in = limit_ff;
      drive_in = drive_ff;
      if (req_accept) begin
         idle_in  = idle_hit ? '0 : idle_pressed;
         call_in  = calls_idle;
         move_in  = move_inc;
         if (hold_hit) begin
            drive_in = cfg.hold_drive;
         end
         if (dwell_done) begin
            move_in  = '0;
            cur_in   = tgt_ff;
            call_in  = calls_left;
            tgt_in   = pick_tgt;
            limit_in = pick_limit;
            drive_in = pick_drive;
         end
      end
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         call_ff      <= '0;
         cur_ff       <= '0;
         tgt_ff       <= '0;
         idle_ff      <= '0;
         move_ff      <= '0;
         limit_ff     <= '0;
         drive_ff     <= HoldDriveRst;
         rsp_valid_ff <= 1'b0;
      end else begin
         call_ff      <= call_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         idle_ff      <= idle_in;
         move_ff      <= move_in;
         limit_ff     <= limit_in;
         drive_ff     <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response reports the state before the tick
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_drive_ff <= drive_ff;
         rsp_lamps_ff <= ~(FLOORS'(1) << cur_ff);
         rsp_at_ff    <= cur_ff;
         rsp_head_ff  <= tgt_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_drive   = rsp_drive_ff;
   assign rsp_floor_lamps   = rsp_lamps_ff;
   assign rsp_at_floor      = rsp_at_ff;
   assign rsp_heading_floor = rsp_head_ff;

   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      (FloorW'(FLOORS - 1) >= cur_ff) && (FloorW'(FLOORS - 1) >= tgt_ff))
      else $error("car floor out of range");

   a_parked_no_limit: assert property (@(posedge clock) disable iff (reset)
      (cur_ff == tgt_ff) |-> (limit_ff == '0))
      else $error("nonzero move limit while parked at target");

   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with no response pending");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick produced no response");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(call_ff) && $stable(move_ff) && $stable(tgt_ff)))
      else $error("controller state moved without a tick");

endmodule
